### rtl/core/piecewise_linear_sigmoid_q27_macros.svh
// assertion macros for the piecewise linear sigmoid block
`ifndef PIECEWISE_LINEAR_SIGMOID_Q27_MACROS_SVH
`define PIECEWISE_LINEAR_SIGMOID_Q27_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside of reset
`define PLSIG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// signal must read low in the cycle after reset is applied
`define PLSIG_ASSERT_RESET(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> !(sig)) else $error(msg);

`else

`define PLSIG_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLSIG_ASSERT_RESET(lbl, clk, rst_n, sig, msg)

`endif

`endif

### rtl/core/plsig_pkg.sv
// shared widths, band tables and types for the piecewise linear sigmoid
`timescale 1ns / 1ps
`default_nettype none

package plsig_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int BAND_COUNT = 16;
    localparam int BAND_W     = $clog2(BAND_COUNT);
    localparam int SLOPE_W    = 30;
    localparam int BIAS_W     = 29;
    localparam int FRAC_SHIFT = 27;
    localparam int BIAS_SHIFT = 3;
    // signed sample times zero-extended slope
    localparam int PROD_W     = SAMPLE_W + SLOPE_W;
    localparam int SHR_W      = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = SHR_W + 1;

    // bias value at the origin; every positive-side bias is at or above it
    localparam logic [BIAS_W-1:0] BIAS_MID = 29'd134217728;

    // upper edge of each band, magnitude in q27
    localparam logic [SAMPLE_W-1:0] EDGE_TAB [0:BAND_COUNT-1] = '{
        32'd63656107,  32'd111395083, 32'd153816608, 32'd194953701,
        32'd236865036, 32'd281253298, 32'd329433241, 32'd384154475,
        32'd447714743, 32'd515399149, 32'd589016819, 32'd679940425,
        32'd759830874, 32'd862986200, 32'd965402453, 32'd2147483648
    };

    localparam logic [SLOPE_W-1:0] SLOPE_TAB [0:BAND_COUNT-1] = '{
        30'd529475578, 30'd482862538, 30'd424212188, 30'd361565531,
        30'd298613704, 30'd238039992, 30'd181912633, 30'd132002182,
        30'd89144402,  30'd56020914,  30'd34019888,  30'd18928477,
        30'd9459126,   30'd5291645,   30'd2204341,   30'd177654
    };

    localparam logic [BIAS_W-1:0] POS_BIAS_TAB [0:BAND_COUNT-1] = '{
        29'd134217728, 29'd136981152, 29'd143065818, 29'd152040132,
        29'd163469967, 29'd176832392, 29'd191534255, 29'd206847211,
        29'd222180513, 29'd235991910, 29'd246552465, 29'd254831080,
        29'd260827489, 29'd263776596, 29'd266257920, 29'd268080117
    };

    localparam logic [BIAS_W-1:0] NEG_BIAS_TAB [0:BAND_COUNT-1] = '{
        29'd134217728, 29'd131454303, 29'd125369637, 29'd116395323,
        29'd104965488, 29'd91603063,  29'd76901200,  29'd61588244,
        29'd46254942,  29'd32443545,  29'd21882990,  29'd13604375,
        29'd7607967,   29'd4658859,   29'd2177535,   29'd355339
    };

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic [BIAS_W-1:0]  bias;
    } t_band_sel;

endpackage

`default_nettype wire

### rtl/core/plsig_band.sv
// band selection and slope / bias lookup from the sample magnitude
`timescale 1ns / 1ps
`default_nettype none

module plsig_band
    import plsig_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output t_band_sel                       o_sel
);

    logic [SAMPLE_W-1:0] mag;
    logic [BAND_W-1:0]   pick;
    logic                neg;

    assign neg = i_sample[SAMPLE_W-1];

    // most negative sample has no positive twin: use the largest positive
    always_comb begin
        if (!neg) begin
            mag = i_sample;
        end else if (i_sample == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
            mag = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            mag = -i_sample;
        end
    end

    // first band whose upper edge is not below the magnitude
    always_comb begin
        pick = BAND_W'(BAND_COUNT - 1);
        for (int k = BAND_COUNT - 1; k >= 0; k--) begin
            if (mag <= EDGE_TAB[k]) begin
                pick = BAND_W'(k);
            end
        end
    end

    always_comb begin
        o_sel.slope = SLOPE_TAB[pick];
        o_sel.bias  = neg ? NEG_BIAS_TAB[pick] : POS_BIAS_TAB[pick];
    end

endmodule

`default_nettype wire

### rtl/core/plsig_sat.sv
// product rescale, bias add and saturation to signed 32 bits
`timescale 1ns / 1ps
`default_nettype none

module plsig_sat
    import plsig_pkg::*;
(
    input  wire logic signed [PROD_W-1:0]   i_prod,
    input  wire logic        [BIAS_W-1:0]   i_bias,
    output logic signed      [SAMPLE_W-1:0] o_result
);

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    logic signed [SHR_W-1:0] shr;
    logic signed [SUM_W-1:0] bias_ext;
    logic signed [SUM_W-1:0] sum;

    // taking the upper bits is a floor shift
    assign shr      = i_prod[PROD_W-1:FRAC_SHIFT];
    assign bias_ext = $signed({{(SUM_W-BIAS_W-BIAS_SHIFT){1'b0}}, i_bias,
                               {BIAS_SHIFT{1'b0}}});
    assign sum      = {shr[SHR_W-1], shr} + bias_ext;

    always_comb begin
        if (sum > SAT_MAX) begin
            o_result = SAT_MAX[SAMPLE_W-1:0];
        end else if (sum < SAT_MIN) begin
            o_result = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            o_result = sum[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/core/piecewise_linear_sigmoid_q27.sv
// Piecewise linear sigmoid: one signed q27 sample in, one saturated q31 result
// out. The datapath is a four-register pipeline: input register, band lookup
// register (slope and bias), product register and result register. A transfer
// can be taken on every clock that o_stall is low, so throughput is one item
// per cycle while the result channel is not stalled. The 32x31 multiply has a
// register on each side, and the band search is 16 parallel compares. Each
// stage holds its item while the stage ahead is full, so bubbles close up and
// o_stall rises only when all four stages hold items and i_stall is high.
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_sigmoid_q27_macros.svh"

module piecewise_linear_sigmoid_q27
    import plsig_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed      [SAMPLE_W-1:0] o_sigmoid_out
);

    // stage valid bits
    logic r_s1_valid, n_s1_valid;
    logic r_s2_valid, n_s2_valid;
    logic r_s3_valid, n_s3_valid;
    logic r_out_valid, n_out_valid;

    // stage payloads
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic signed [SAMPLE_W-1:0] r_s2_sample;
    logic        [SLOPE_W-1:0]  r_s2_slope;
    logic        [BIAS_W-1:0]   r_s2_bias;
    logic signed [PROD_W-1:0]   r_s3_prod;
    logic        [BIAS_W-1:0]   r_s3_bias;
    logic signed [SAMPLE_W-1:0] r_out_data;

    // a stage is free when it is empty or its item leaves this cycle
    logic out_free, s3_free, s2_free, s1_free;

    t_band_sel                  band_sel;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SAMPLE_W-1:0] sat_result;

    assign out_free = !r_out_valid || !i_stall;
    assign s3_free  = !r_s3_valid || out_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;

    assign o_stall       = !s1_free;
    assign o_valid       = r_out_valid;
    assign o_sigmoid_out = r_out_data;

    // band search and table read on the registered sample
    plsig_band u_band (
        .i_sample (r_s1_sample),
        .o_sel    (band_sel)
    );

    // slope is always positive: zero-extend it into a signed operand
    assign prod = r_s2_sample * $signed({1'b0, r_s2_slope});

    // floor shift, bias add, clamp
    plsig_sat u_sat (
        .i_prod   (r_s3_prod),
        .i_bias   (r_s3_bias),
        .o_result (sat_result)
    );

    always_comb begin
        n_s1_valid  = s1_free  ? i_valid     : r_s1_valid;
        n_s2_valid  = s2_free  ? r_s1_valid  : r_s2_valid;
        n_s3_valid  = s3_free  ? r_s2_valid  : r_s3_valid;
        n_out_valid = out_free ? r_s3_valid  : r_out_valid;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_s3_valid  <= n_s3_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, loaded only when an item moves in
    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_sample <= i_sample_in;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_sample <= r_s1_sample;
            r_s2_slope  <= band_sel.slope;
            r_s2_bias   <= band_sel.bias;
        end
        if (s3_free && r_s2_valid) begin
            r_s3_prod <= prod;
            r_s3_bias <= r_s2_bias;
        end
        if (out_free && r_s3_valid) begin
            r_out_data <= sat_result;
        end
    end

    // pipeline empties on reset
    `PLSIG_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n,
        r_s1_valid || r_s2_valid || r_s3_valid || r_out_valid,
        "pipeline not empty after reset")

    // input is held off only when every stage is occupied
    `PLSIG_ASSERT(a_stall_full, i_clk, i_rst_n,
        o_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_out_valid),
        "input stalled with a free stage")

    // a product that cannot advance is kept intact
    `PLSIG_ASSERT(a_prod_hold, i_clk, i_rst_n,
        (r_s3_valid && !out_free) |=> (r_s3_valid && $stable(r_s3_prod)),
        "blocked product stage lost its item")

    // positive side bias table never drops below the origin value
    `PLSIG_ASSERT(a_pos_bias, i_clk, i_rst_n,
        (r_s2_valid && !r_s2_sample[SAMPLE_W-1]) |-> (r_s2_bias >= BIAS_MID),
        "non-negative sample picked a negative-side bias")

endmodule

`default_nettype wire
